// File: src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the line pixel rasterizer modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_BITS = 12;
    localparam int SPAN_BITS  = COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SPAN_BITS-1:0]  span_t;

    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } lpr_op_t;

    typedef struct packed {
        lpr_op_t opcode;
        coord_t  x_start;
        coord_t  y_start;
        coord_t  x_end;
        coord_t  y_end;
    } lpr_cmd_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } lpr_pixel_t;

    typedef struct packed {
        logic   line_active;
        logic   steep_flag;
        coord_t major_pos;
        coord_t major_end;
        coord_t minor_pos;
        span_t  major_span;
        span_t  minor_span;
        logic   minor_negative;
        span_t  remainder_acc;
    } lpr_state_t;

endpackage

// File: src/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Integer line rasterizer: a load beat sets up a line, each advance beat
// emits the next pixel with an exact remainder-based minor coordinate.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+---------------------
//   cmd     | cmd_valid    | cmd_stall    | cmd   (lpr_cmd_t)
//   pixel   | pixel_valid  | pixel_stall  | pixel (lpr_pixel_t)
//
// One beat per cycle while cmd_stall is low. Accepted beats update the
// line state; pixels are registered in the output slot or the skid.
// Reset clears the line state and both output slots.
// A two-slot output (register plus skid) keeps cmd open through one stall;
// cmd_stall rises only while both slots hold pixels.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  lpr_pkg::lpr_cmd_t   cmd,
    output logic                pixel_valid,
    input  logic                pixel_stall,
    output lpr_pkg::lpr_pixel_t pixel
);

    lpr_pkg::lpr_state_t state_reg;
    lpr_pkg::lpr_state_t state_next;
    lpr_pkg::lpr_state_t state_load;
    lpr_pkg::lpr_state_t state_adv;
    lpr_pkg::lpr_pixel_t step_pixel;

    logic                out_valid_reg;
    logic                out_valid_next;
    lpr_pkg::lpr_pixel_t out_reg;
    lpr_pkg::lpr_pixel_t out_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    lpr_pkg::lpr_pixel_t skid_reg;
    lpr_pkg::lpr_pixel_t skid_next;

    logic                accept;
    logic                emit;
    logic                out_free;

    lpr_setup u_setup (
        .cmd   (cmd),
        .state (state_load)
    );

    lpr_step u_step (
        .state     (state_reg),
        .state_adv (state_adv),
        .pixel     (step_pixel)
    );

    assign cmd_stall   = skid_valid_reg;
    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    assign accept   = cmd_valid && !cmd_stall;
    assign emit     = accept && (cmd.opcode == lpr_pkg::OP_ADVANCE) && state_reg.line_active;
    assign out_free = !out_valid_reg || !pixel_stall;

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            if (cmd.opcode == lpr_pkg::OP_LOAD)
            begin
                state_next = state_load;
            end
            else if (state_reg.line_active)
            begin
                state_next = state_adv;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = emit;
                out_next       = step_pixel;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_next       = step_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// File: src/lpr_setup.sv
// ----------------------------------------------------------------------------
// lpr_setup
// Line setup: swap steep axes, order endpoints, derive spans and direction.
// ----------------------------------------------------------------------------
module lpr_setup (
    input  lpr_pkg::lpr_cmd_t   cmd,
    output lpr_pkg::lpr_state_t state
);

    lpr_pkg::coord_t dx;
    lpr_pkg::coord_t dy;
    logic            steep;
    lpr_pkg::coord_t ma;
    lpr_pkg::coord_t na;
    lpr_pkg::coord_t mb;
    lpr_pkg::coord_t nb;
    lpr_pkg::coord_t m0;
    lpr_pkg::coord_t n0;
    lpr_pkg::coord_t m1;
    lpr_pkg::coord_t n1;
    lpr_pkg::coord_t dn;

    always_comb
    begin
        dx    = (cmd.x_start > cmd.x_end) ? (cmd.x_start - cmd.x_end)
                                          : (cmd.x_end - cmd.x_start);
        dy    = (cmd.y_start > cmd.y_end) ? (cmd.y_start - cmd.y_end)
                                          : (cmd.y_end - cmd.y_start);
        steep = dy > dx;

        if (steep)
        begin
            ma = cmd.y_start;
            na = cmd.x_start;
            mb = cmd.y_end;
            nb = cmd.x_end;
        end
        else
        begin
            ma = cmd.x_start;
            na = cmd.y_start;
            mb = cmd.x_end;
            nb = cmd.y_end;
        end

        if (ma > mb)
        begin
            m0 = mb;
            n0 = nb;
            m1 = ma;
            n1 = na;
        end
        else
        begin
            m0 = ma;
            n0 = na;
            m1 = mb;
            n1 = nb;
        end

        dn = (n0 > n1) ? (n0 - n1) : (n1 - n0);

        state.line_active    = m0 != m1;
        state.steep_flag     = steep;
        state.major_pos      = m0;
        state.major_end      = m1;
        state.minor_pos      = n0;
        state.major_span     = {1'b0, m1} - {1'b0, m0};
        state.minor_span     = {1'b0, dn};
        state.minor_negative = n1 < n0;
        state.remainder_acc  = '0;
    end

endmodule

// File: src/lpr_step.sv
// ----------------------------------------------------------------------------
// lpr_step
// Pixel step: emit the current pixel and advance the remainder accumulator.
// ----------------------------------------------------------------------------
module lpr_step (
    input  lpr_pkg::lpr_state_t state,
    output lpr_pkg::lpr_state_t state_adv,
    output lpr_pkg::lpr_pixel_t pixel
);

    lpr_pkg::coord_t major_inc;
    lpr_pkg::span_t  rem_up;
    logic            last;

    always_comb
    begin
        major_inc = state.major_pos + lpr_pkg::coord_t'(1);
        last      = major_inc == state.major_end;
        rem_up    = state.remainder_acc + state.minor_span;

        pixel.pixel_x    = state.steep_flag ? state.minor_pos : state.major_pos;
        pixel.pixel_y    = state.steep_flag ? state.major_pos : state.minor_pos;
        pixel.last_pixel = last;

        state_adv           = state;
        state_adv.major_pos = major_inc;
        if (last)
        begin
            state_adv.line_active = 1'b0;
        end

        if (state.minor_negative)
        begin
            if (state.remainder_acc < state.minor_span)
            begin
                state_adv.remainder_acc = state.remainder_acc + state.major_span
                                          - state.minor_span;
                state_adv.minor_pos     = state.minor_pos - lpr_pkg::coord_t'(1);
            end
            else
            begin
                state_adv.remainder_acc = state.remainder_acc - state.minor_span;
            end
        end
        else
        begin
            if (rem_up >= state.major_span)
            begin
                state_adv.remainder_acc = rem_up - state.major_span;
                state_adv.minor_pos     = state.minor_pos + lpr_pkg::coord_t'(1);
            end
            else
            begin
                state_adv.remainder_acc = rem_up;
            end
        end
    end

endmodule

// File: src/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks for the line pixel rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lpr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input lpr_pkg::lpr_cmd_t   cmd,
    input logic                pixel_valid,
    input logic                pixel_stall,
    input lpr_pkg::lpr_pixel_t pixel
);

    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
        else $error("stalled pixel beat dropped or changed");

    a_stall_needs_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> pixel_valid)
        else $error("cmd stalled with no pixel pending");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_stall) |-> $past(pixel_valid && pixel_stall))
        else $error("cmd stall rose without a stalled pixel");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.opcode == lpr_pkg::OP_LOAD) && !pixel_valid
        |=> !pixel_valid)
        else $error("load beat produced a pixel");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
);
